>>> rtl/id_ordered_pulse_ring_buffer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse ring buffer
// Shared property forms for the modules that carry concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ID_ORDERED_PULSE_RING_BUFFER_TOP_MACROS_SVH
`define ID_ORDERED_PULSE_RING_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IOPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IOPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iopr_pkg.sv
// ----------------------------------------------------------------------------
// Pulse ring buffer package
// Sizes, command codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package iopr_pkg;

  // Ring depth; must be a power of two so slot arithmetic wraps naturally.
  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = 7;
  localparam int ID_W         = 64;
  localparam int CMD_W        = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // Transaction commands.
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LATEST = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic item_ld;
    logic rd_issue;
    logic off_ld_zero;
    logic off_ld_last;
    logic off_ld_first;
    logic first_ld_match;
    logic first_ld_latest;
    logic exp_ld;
    logic exp_inc;
    logic push_wr;
    logic out_ld_one;
    logic out_ld_rec;
    logic one_rej;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cap_zero;
    logic             fill_zero;
    logic             read_bad;
    logic             push_id_bad;
    logic             rd_vld;
    logic             id_match;
    logic             scan_end;
    logic             srch_more;
    logic             run_bad;
    logic             run_first;
    logic             chk_bad;
    logic             run_end;
    logic             issue_more;
    logic             out_free;
  } dp_sts_t;

endpackage

>>> rtl/iopr_dp.sv
// ----------------------------------------------------------------------------
// Pulse ring buffer datapath
// Record memories, ring pointers, scan counters and the output register.
// ----------------------------------------------------------------------------
`include "id_ordered_pulse_ring_buffer_top_macros.svh"

module iopr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [iopr_pkg::CNT_W-1:0]       cfg_wr_data,
  input  logic [iopr_pkg::CMD_W-1:0]       in_cmd,
  input  logic [iopr_pkg::ID_W-1:0]        in_pulse_id,
  input  logic [63:0]                      in_payload,
  input  logic [iopr_pkg::CNT_W-1:0]       in_count,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic                             out_status,
  output logic [63:0]                      out_rec_id,
  output logic [63:0]                      out_rec_payload,
  output logic                             out_last,
  output logic [iopr_pkg::CNT_W-1:0]       out_fill_level,
  output logic                             out_overflow_flag,
  input  iopr_pkg::dp_cmd_t                dp_cmd,
  output iopr_pkg::dp_sts_t                dp_sts
);

  localparam int AW = iopr_pkg::ADDR_W;
  localparam int CW = iopr_pkg::CNT_W;
  localparam int PW = iopr_pkg::PAYLOAD_BITS;
  localparam int IW = iopr_pkg::ID_W;

  // Record storage.
  logic [IW-1:0] id_mem  [iopr_pkg::DEPTH];
  logic [PW-1:0] pay_mem [iopr_pkg::DEPTH];

  // Configuration and ring state.
  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;

  // Latched transaction.
  logic [iopr_pkg::CMD_W-1:0] cmd_r;
  logic [IW-1:0]              pid_r;
  logic [PW-1:0]              pay_r;
  logic [CW-1:0]              count_r;

  // Scan state.
  logic [CW-1:0] off_r, off_nxt;
  logic          dv_r;
  logic [CW-1:0] doff_r;
  logic [CW-1:0] first_r, first_nxt;
  logic [IW-1:0] expect_r, expect_nxt;
  logic [IW-1:0] rd_id_r;
  logic [PW-1:0] rd_pay_r;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r;
  logic [IW-1:0] out_id_r;
  logic [PW-1:0] out_pay_r;
  logic          out_last_r;
  logic [CW-1:0] out_fill_r;
  logic          out_ovf_r;

  logic [CW-1:0] eff_cap;
  logic          full;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW:0]   end_w;
  logic [CW:0]   doff_inc;
  logic          out_free;

  // Effective capacity saturates at the ring depth.
  assign eff_cap = (cap_r > CW'(iopr_pkg::DEPTH)) ? CW'(iopr_pkg::DEPTH) : cap_r;
  assign full    = (fill_r >= eff_cap);

  // Slot addresses wrap modulo the power-of-two depth.
  assign rd_addr  = oldest_r + off_r[AW-1:0];
  assign wr_addr  = oldest_r + fill_r[AW-1:0];
  assign end_w    = {1'b0, first_r} + {1'b0, count_r};
  assign doff_inc = {1'b0, doff_r} + (CW+1)'(1);
  assign out_free = !out_valid_r || !out_stall;

  // Status toward the controller.
  always_comb begin
    dp_sts.cmd         = cmd_r;
    dp_sts.cap_zero    = (eff_cap == '0);
    dp_sts.fill_zero   = (fill_r == '0);
    dp_sts.read_bad    = (count_r == '0) || (count_r > fill_r);
    dp_sts.push_id_bad = (pid_r <= rd_id_r);
    dp_sts.rd_vld      = dv_r;
    dp_sts.id_match    = (rd_id_r == pid_r);
    dp_sts.scan_end    = (doff_r == fill_r - CW'(1));
    dp_sts.srch_more   = (off_r < fill_r);
    dp_sts.run_bad     = (end_w > {1'b0, fill_r});
    dp_sts.run_first   = (doff_r == first_r);
    dp_sts.chk_bad     = (rd_id_r != expect_r);
    dp_sts.run_end     = (doff_inc == end_w);
    dp_sts.issue_more  = ({1'b0, off_r} != end_w);
    dp_sts.out_free    = out_free;
  end

  // Ring state and scan counter next values.
  always_comb begin
    cap_nxt    = cap_r;
    oldest_nxt = oldest_r;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    off_nxt    = off_r;
    first_nxt  = first_r;
    expect_nxt = expect_r;
    if (cfg_wr_en) begin
      cap_nxt = cfg_wr_data;
    end
    // A push into a full ring drops the oldest record and keeps the fill.
    if (dp_cmd.push_wr) begin
      if (full) begin
        oldest_nxt = oldest_r + AW'(1);
        ovf_nxt    = 1'b1;
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end
    if (dp_cmd.off_ld_zero) begin
      off_nxt = '0;
    end else if (dp_cmd.off_ld_last) begin
      off_nxt = fill_r - CW'(1);
    end else if (dp_cmd.off_ld_first) begin
      off_nxt = first_r;
    end else if (dp_cmd.rd_issue) begin
      off_nxt = off_r + CW'(1);
    end
    if (dp_cmd.first_ld_match) begin
      first_nxt = doff_r;
    end else if (dp_cmd.first_ld_latest) begin
      first_nxt = fill_r - count_r;
    end
    if (dp_cmd.exp_ld) begin
      expect_nxt = rd_id_r + IW'(1);
    end else if (dp_cmd.exp_inc) begin
      expect_nxt = expect_r + IW'(1);
    end
  end

  // Output register: loaded by the controller, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.out_ld_one || dp_cmd.out_ld_rec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= iopr_pkg::CAP_RESET;
      oldest_r    <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      oldest_r    <= oldest_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      dv_r        <= dp_cmd.rd_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Transaction and scan payload registers.
  always_ff @(posedge clk) begin
    off_r    <= off_nxt;
    first_r  <= first_nxt;
    expect_r <= expect_nxt;
    if (dp_cmd.item_ld) begin
      cmd_r   <= in_cmd;
      pid_r   <= in_pulse_id;
      pay_r   <= in_payload[PW-1:0];
      count_r <= in_count;
    end
    if (dp_cmd.rd_issue) begin
      doff_r <= off_r;
    end
  end

  // Record memories with registered read data.
  always_ff @(posedge clk) begin
    if (dp_cmd.push_wr) begin
      id_mem[wr_addr]  <= pid_r;
      pay_mem[wr_addr] <= pay_r;
    end
    if (dp_cmd.rd_issue) begin
      rd_id_r  <= id_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
    end
  end

  // Output payload: a single status result or one emitted record.
  always_ff @(posedge clk) begin
    if (dp_cmd.out_ld_one) begin
      out_status_r <= dp_cmd.one_rej;
      out_id_r     <= '0;
      out_pay_r    <= '0;
      out_last_r   <= 1'b1;
      out_fill_r   <= fill_r;
      out_ovf_r    <= ovf_r;
    end else if (dp_cmd.out_ld_rec) begin
      out_status_r <= 1'b0;
      out_id_r     <= rd_id_r;
      out_pay_r    <= rd_pay_r;
      out_last_r   <= dp_sts.run_end;
      out_fill_r   <= fill_r;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_rec_id        = out_id_r;
  assign out_rec_payload   = 64'(out_pay_r);
  assign out_last          = out_last_r;
  assign out_fill_level    = out_fill_r;
  assign out_overflow_flag = out_ovf_r;

  // A push into a ring with room grows the fill by one.
  `IOPR_ASSERT_NXT(a_push_grow, clk, rst_n, dp_cmd.push_wr && !full, fill_r == $past(fill_r) + CW'(1), "push with room did not grow fill")
  // A push into a full ring keeps the fill and raises the overflow flag.
  `IOPR_ASSERT_NXT(a_push_full, clk, rst_n, dp_cmd.push_wr && full, ovf_r && (fill_r == $past(fill_r)), "push into full ring mishandled")
  // The overflow flag is sticky until reset.
  `IOPR_ASSERT_NXT(a_ovf_sticky, clk, rst_n, ovf_r, ovf_r, "overflow flag cleared")

endmodule

>>> rtl/iopr_ctrl.sv
// ----------------------------------------------------------------------------
// Pulse ring buffer controller
// Sequences push checks, id search, consecutive-id check and record emission.
// ----------------------------------------------------------------------------
`include "id_ordered_pulse_ring_buffer_top_macros.svh"

module iopr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  iopr_pkg::dp_sts_t dp_sts,
  output iopr_pkg::dp_cmd_t dp_cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PRD    = 4'd2;
  localparam logic [3:0] S_PCMP   = 4'd3;
  localparam logic [3:0] S_PWR    = 4'd4;
  localparam logic [3:0] S_ONE    = 4'd5;
  localparam logic [3:0] S_SRCH   = 4'd6;
  localparam logic [3:0] S_RUN0   = 4'd7;
  localparam logic [3:0] S_CHK    = 4'd8;
  localparam logic [3:0] S_ERD    = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       rej_r, rej_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    rej_nxt   = rej_r;
    dp_cmd    = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.item_ld = 1'b1;
          state_nxt      = S_DECODE;
        end
      end
      S_DECODE: begin
        if (dp_sts.cmd == iopr_pkg::CMD_PUSH) begin
          if (dp_sts.cap_zero) begin
            rej_nxt   = 1'b1;
            state_nxt = S_ONE;
          end else if (dp_sts.fill_zero) begin
            state_nxt = S_PWR;
          end else begin
            dp_cmd.off_ld_last = 1'b1;
            state_nxt          = S_PRD;
          end
        end else if (dp_sts.read_bad) begin
          rej_nxt   = 1'b1;
          state_nxt = S_ONE;
        end else if (dp_sts.cmd == iopr_pkg::CMD_RANGE) begin
          dp_cmd.off_ld_zero = 1'b1;
          state_nxt          = S_SRCH;
        end else if (dp_sts.cmd == iopr_pkg::CMD_LATEST) begin
          dp_cmd.first_ld_latest = 1'b1;
          state_nxt              = S_RUN0;
        end else begin
          rej_nxt   = 1'b1;
          state_nxt = S_ONE;
        end
      end
      // Fetch the newest id to check that the new id is above it.
      S_PRD: begin
        dp_cmd.rd_issue = 1'b1;
        state_nxt       = S_PCMP;
      end
      S_PCMP: begin
        if (dp_sts.push_id_bad) begin
          rej_nxt   = 1'b1;
          state_nxt = S_ONE;
        end else begin
          state_nxt = S_PWR;
        end
      end
      S_PWR: begin
        dp_cmd.push_wr = 1'b1;
        rej_nxt        = 1'b0;
        state_nxt      = S_ONE;
      end
      S_ONE: begin
        if (dp_sts.out_free) begin
          dp_cmd.out_ld_one = 1'b1;
          dp_cmd.one_rej    = rej_r;
          state_nxt         = S_IDLE;
        end
      end
      // Pipelined scan from the oldest record for the requested id.
      S_SRCH: begin
        dp_cmd.rd_issue = dp_sts.srch_more;
        if (dp_sts.rd_vld) begin
          if (dp_sts.id_match) begin
            dp_cmd.rd_issue       = 1'b0;
            dp_cmd.first_ld_match = 1'b1;
            state_nxt             = S_RUN0;
          end else if (dp_sts.scan_end) begin
            rej_nxt   = 1'b1;
            state_nxt = S_ONE;
          end
        end
      end
      S_RUN0: begin
        if (dp_sts.run_bad) begin
          rej_nxt   = 1'b1;
          state_nxt = S_ONE;
        end else begin
          dp_cmd.off_ld_first = 1'b1;
          state_nxt           = S_CHK;
        end
      end
      // Pipelined pass checking that the run's ids are consecutive.
      S_CHK: begin
        dp_cmd.rd_issue = dp_sts.issue_more;
        if (dp_sts.rd_vld) begin
          if (dp_sts.run_first) begin
            dp_cmd.exp_ld = 1'b1;
          end else if (dp_sts.chk_bad) begin
            rej_nxt   = 1'b1;
            state_nxt = S_ONE;
          end else begin
            dp_cmd.exp_inc = 1'b1;
          end
          if (dp_sts.run_end && (dp_sts.run_first || !dp_sts.chk_bad)) begin
            dp_cmd.rd_issue     = 1'b0;
            dp_cmd.off_ld_first = 1'b1;
            state_nxt           = S_ERD;
          end
        end
      end
      S_ERD: begin
        dp_cmd.rd_issue = 1'b1;
        state_nxt       = S_EMIT;
      end
      // Emit one record per free output slot, fetching the next meanwhile.
      S_EMIT: begin
        if (dp_sts.out_free) begin
          dp_cmd.out_ld_rec = 1'b1;
          if (dp_sts.run_end) begin
            state_nxt = S_IDLE;
          end else begin
            dp_cmd.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // The output register is only loaded when it is free.
  `IOPR_ASSERT_IMP(a_ld_free, clk, rst_n, dp_cmd.out_ld_one || dp_cmd.out_ld_rec, dp_sts.out_free, "output loaded while occupied")
  // An accepted transaction always goes to decode.
  `IOPR_ASSERT_NXT(a_acc_decode, clk, rst_n, accept, state_r == S_DECODE, "accept did not start decode")
  // Emission continues until the final record of the run.
  `IOPR_ASSERT_NXT(a_emit_cont, clk, rst_n, (state_r == S_EMIT) && dp_cmd.out_ld_rec && !dp_sts.run_end, state_r == S_EMIT, "emission stopped early")

endmodule

>>> rtl/id_ordered_pulse_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// Id-ordered pulse ring buffer
// Overwrite-oldest ring of 64 id/payload records with push, range read and
// latest read commands.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) takes one transaction at a time:
//   a push, a read of count records from a given id, or a read of the newest
//   count records. in_stall stays high until every result of the current
//   transaction has been loaded into the output register.
//   The output channel (out_valid/out_stall) gives one result per push or
//   rejected read, and count results per accepted read, with out_last on the
//   final one. A held result stays stable while out_stall is high; the block
//   pauses its work until the output register is free.
//   A push first reads the newest id to check the new one (not on an empty
//   ring). A read first checks that the ids of its run are consecutive,
//   then loads one record per free output cycle; a range read first scans
//   from the oldest record for its id. One transaction at a time; the single
//   read port of the record memory sets the pace.
//   cfg_wr_en/cfg_wr_data write the capacity register; write only when idle.
//   Reset empties the ring, clears the overflow flag and sets capacity to 64;
//   record memory contents are left as they are.
// ----------------------------------------------------------------------------
module id_ordered_pulse_ring_buffer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [iopr_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [iopr_pkg::CMD_W-1:0] in_cmd,
  input  logic [63:0]                in_pulse_id,
  input  logic [63:0]                in_payload,
  input  logic [iopr_pkg::CNT_W-1:0] in_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [63:0]                out_rec_id,
  output logic [63:0]                out_rec_payload,
  output logic                       out_last,
  output logic [iopr_pkg::CNT_W-1:0] out_fill_level,
  output logic                       out_overflow_flag
);

  iopr_pkg::dp_cmd_t dp_cmd;
  iopr_pkg::dp_sts_t dp_sts;

  // Sequencer.
  iopr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_sts   (dp_sts),
    .dp_cmd   (dp_cmd)
  );

  // Storage, pointers and output register.
  iopr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_cmd            (in_cmd),
    .in_pulse_id       (in_pulse_id),
    .in_payload        (in_payload),
    .in_count          (in_count),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_rec_id        (out_rec_id),
    .out_rec_payload   (out_rec_payload),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level),
    .out_overflow_flag (out_overflow_flag),
    .dp_cmd            (dp_cmd),
    .dp_sts            (dp_sts)
  );

endmodule

>>> tb/ring_record_checker.sv
// ----------------------------------------------------------------------------
// Pulse ring buffer result checker
// Watches the configuration port and both channels, keeps its own copy of the
// record ring, predicts the results of every accepted transaction and compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ring_record_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [iopr_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [iopr_pkg::CMD_W-1:0] in_cmd,
  input  logic [63:0]                in_pulse_id,
  input  logic [63:0]                in_payload,
  input  logic [iopr_pkg::CNT_W-1:0] in_count,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_status,
  input  logic [63:0]                out_rec_id,
  input  logic [63:0]                out_rec_payload,
  input  logic                       out_last,
  input  logic [iopr_pkg::CNT_W-1:0] out_fill_level,
  input  logic                       out_overflow_flag,
  output int                         mismatch_cnt,
  output int                         records_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import iopr_pkg::*;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REJ     = 1'b1;
  localparam int   REPORT_MAX = 10;

  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  rec_id;
    logic [63:0]      rec_payload;
    logic             last;
    logic [CNT_W-1:0] fill;
    logic             ovf;
  } ring_rec_t;

  // Predicted results still waiting for the output channel.
  ring_rec_t expected_records[$];

  // Shadow copy of the ring and its control state.
  logic [ID_W-1:0]  ring_id  [DEPTH];
  logic [63:0]      ring_pay [DEPTH];
  logic [ADDR_W-1:0] oldest    = '0;
  int unsigned       held      = 0;
  logic              ovf_seen  = 1'b0;
  logic [CNT_W-1:0]  capacity  = CAP_RESET;

  int fail_total = 0;
  int due_total  = 0;

  assign mismatch_cnt = fail_total;
  assign records_due  = due_total;

  // Ring slot of the record that lies off places after the oldest one.
  function automatic logic [ADDR_W-1:0] ring_slot(int unsigned off);
    return ADDR_W'(oldest + off);
  endfunction

  task automatic queue_record(logic st, logic [ID_W-1:0] id, logic [63:0] pay, logic lst);
    ring_rec_t r;
    r.status      = st;
    r.rec_id      = id;
    r.rec_payload = pay;
    r.last        = lst;
    r.fill        = CNT_W'(held);
    r.ovf         = ovf_seen;
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic queue_reject();
    queue_record(ST_REJ, '0, '0, 1'b1);
  endtask

  // A run of n records from ring offset first is emitted only when it stays
  // inside the ring and its ids are consecutive.
  task automatic emit_run(int unsigned first, int unsigned n);
    logic [ID_W-1:0] base;
    if (n == 0 || first + n > held) begin
      queue_reject();
      return;
    end
    base = ring_id[ring_slot(first)];
    for (int unsigned i = 1; i < n; i++) begin
      if (ring_id[ring_slot(first + i)] != base + ID_W'(i)) begin
        queue_reject();
        return;
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      queue_record(ST_OK, ring_id[ring_slot(first + i)], ring_pay[ring_slot(first + i)],
                   i + 1 == n);
    end
  endtask

  // Applies one accepted transaction to the shadow ring and queues its results.
  task automatic apply_ring_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] pid,
                                    logic [63:0] pay, logic [CNT_W-1:0] cnt);
    int unsigned eff_cap;
    int unsigned hit;
    bit          found;
    eff_cap = (capacity > DEPTH) ? DEPTH : capacity;
    found   = 1'b0;
    hit     = 0;
    if (cmd == CMD_PUSH) begin
      if (eff_cap == 0 || (held > 0 && pid <= ring_id[ring_slot(held - 1)])) begin
        queue_reject();
      end else begin
        // A full ring, or one whose capacity was lowered, loses its oldest record.
        if (held >= eff_cap) begin
          oldest   = ring_slot(1);
          held     = held - 1;
          ovf_seen = 1'b1;
        end
        ring_id[ring_slot(held)]  = pid;
        ring_pay[ring_slot(held)] = 64'(pay[PAYLOAD_BITS-1:0]);
        held = held + 1;
        queue_record(ST_OK, '0, '0, 1'b1);
      end
    end else if (cnt == 0 || cnt > held) begin
      queue_reject();
    end else if (cmd == CMD_RANGE) begin
      for (int unsigned i = 0; i < held; i++) begin
        if (!found && ring_id[ring_slot(i)] == pid) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        emit_run(hit, cnt);
      end else begin
        queue_reject();
      end
    end else if (cmd == CMD_LATEST) begin
      emit_run(held - cnt, cnt);
    end else begin
      queue_reject();
    end
  endtask

  task automatic check_result(ring_rec_t got);
    ring_rec_t want;
    if (expected_records.size() == 0) begin
      fail_total++;
      if (fail_total <= REPORT_MAX) begin
        $display("%0t: result with nothing expected: st=%0d id=%h pay=%h last=%0d",
                 $time, got.status, got.rec_id, got.rec_payload, got.last);
      end
      return;
    end
    want = expected_records[0];
    expected_records.delete(0);
    if (got.status !== want.status || got.rec_id !== want.rec_id ||
        got.rec_payload !== want.rec_payload || got.last !== want.last ||
        got.fill !== want.fill || got.ovf !== want.ovf) begin
      fail_total++;
      if (fail_total <= REPORT_MAX) begin
        $display("%0t: result mismatch", $time);
        $display("  expected st=%0d id=%h pay=%h last=%0d fill=%0d ovf=%0d",
                 want.status, want.rec_id, want.rec_payload, want.last, want.fill, want.ovf);
        $display("  actual   st=%0d id=%h pay=%h last=%0d fill=%0d ovf=%0d",
                 got.status, got.rec_id, got.rec_payload, got.last, got.fill, got.ovf);
      end
    end
  endtask

  // All channel activity is sampled at the rising edge.
  always @(posedge clk) begin
    ring_rec_t seen;
    if (!rst_n) begin
      oldest   = '0;
      held     = 0;
      ovf_seen = 1'b0;
      capacity = CAP_RESET;
      expected_records.delete();
    end else begin
      if (cfg_wr_en) begin
        capacity = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        apply_ring_command(in_cmd, in_pulse_id, in_payload, in_count);
      end
      if (out_valid && !out_stall) begin
        seen.status      = out_status;
        seen.rec_id      = out_rec_id;
        seen.rec_payload = out_rec_payload;
        seen.last        = out_last;
        seen.fill        = out_fill_level;
        seen.ovf         = out_overflow_flag;
        check_result(seen);
      end
    end
    due_total = expected_records.size();
  end

endmodule

>>> tb/tb_id_ordered_pulse_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// Pulse ring buffer testbench
// Drives directed and random push and read transactions through the ring
// buffer under several capacity settings and idling patterns; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_id_ordered_pulse_ring_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iopr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int               CYCLE_LIMIT = 1_000_000;
  localparam int               QUIET_CYCLES = 20;
  localparam logic [ID_W-1:0]  ID_TOP      = '1;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic [CMD_W-1:0] in_cmd      = CMD_PUSH;
  logic [63:0]      in_pulse_id = '0;
  logic [63:0]      in_payload  = '0;
  logic [CNT_W-1:0] in_count    = '0;
  logic             out_stall   = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic             out_status;
  logic [63:0]      out_rec_id;
  logic [63:0]      out_rec_payload;
  logic             out_last;
  logic [CNT_W-1:0] out_fill_level;
  logic             out_overflow_flag;

  int               fail_cnt;
  int               records_due;
  int unsigned      idle_pct  = 0;
  int unsigned      stall_pct = 0;
  int               cycles    = 0;
  logic [ID_W-1:0]  newest    = '0;

  always #2 clk = ~clk;

  id_ordered_pulse_ring_buffer_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_pulse_id       (in_pulse_id),
    .in_payload        (in_payload),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_rec_id        (out_rec_id),
    .out_rec_payload   (out_rec_payload),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level),
    .out_overflow_flag (out_overflow_flag)
  );

  ring_record_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_pulse_id       (in_pulse_id),
    .in_payload        (in_payload),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_rec_id        (out_rec_id),
    .out_rec_payload   (out_rec_payload),
    .out_last          (out_last),
    .out_fill_level    (out_fill_level),
    .out_overflow_flag (out_overflow_flag),
    .mismatch_cnt      (fail_cnt),
    .records_due       (records_due)
  );

  // Receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_id_ordered_pulse_ring_buffer_top NOT OK");
      $finish;
    end
  end

  // Presents one transaction after a random idle gap and waits until it is taken.
  task automatic send(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [63:0] pay,
                      logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_pulse_id <= id;
    in_payload  <= pay;
    in_count    <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every predicted result has been seen and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (records_due != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] cap);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Read sizes are mostly short, sometimes long, now and then out of range.
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return CNT_W'($urandom_range(8, 1));
    else if (r < 93) return CNT_W'($urandom_range(64, 9));
    else if (r < 96) return '0;
    else return CNT_W'($urandom_range(127, 65));
  endfunction

  // Mostly well-formed pushes with rising ids and reads near the newest
  // records, with stale pushes, absent ids and unknown commands mixed in.
  task automatic random_item();
    int unsigned r;
    logic [63:0] pay;
    pay = {$urandom, $urandom};
    r   = $urandom_range(99);
    if (r < 35) begin
      newest = newest + 1;
      send(CMD_PUSH, newest, pay, pick_count());
    end else if (r < 45) begin
      newest = newest + ID_W'($urandom_range(5, 2));
      send(CMD_PUSH, newest, pay, pick_count());
    end else if (r < 52) begin
      send(CMD_PUSH, newest - ID_W'($urandom_range(2, 0)), pay, pick_count());
    end else if (r < 70) begin
      send(CMD_LATEST, {$urandom, $urandom}, pay, pick_count());
    end else if (r < 88) begin
      send(CMD_RANGE, newest - ID_W'($urandom_range(70, 0)), pay, pick_count());
    end else if (r < 95) begin
      send(CMD_RANGE, {$urandom, $urandom}, pay, pick_count());
    end else begin
      send(CMD_UNUSED, {$urandom, $urandom}, pay, CNT_W'($urandom));
    end
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cap, int unsigned idle, int unsigned stall,
                           int n);
    write_capacity(cap);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) random_item();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reads on an empty ring, then a short run of pushes and reads.
    send(CMD_LATEST, '0, '0, CNT_W'(1));
    send(CMD_RANGE, '0, '0, CNT_W'(1));
    send(CMD_PUSH, '0, '0, '0);
    send(CMD_PUSH, '0, '1, '0);
    send(CMD_PUSH, 64'd1, '1, '0);
    send(CMD_PUSH, 64'd2, 64'h0123_4567_89ab_cdef, '1);
    send(CMD_LATEST, '0, '0, CNT_W'(3));
    send(CMD_RANGE, 64'd1, '0, CNT_W'(2));
    // Range running past the newest record, absent id, bad counts, unknown command.
    send(CMD_RANGE, 64'd1, '0, CNT_W'(3));
    send(CMD_RANGE, 64'd7, '0, CNT_W'(1));
    send(CMD_LATEST, '0, '0, '0);
    send(CMD_LATEST, '0, '0, CNT_W'(64));
    send(CMD_RANGE, '0, '0, '1);
    send(CMD_UNUSED, '1, '1, '1);
    // A gap in the ids makes runs across it non-consecutive.
    send(CMD_PUSH, 64'd5, 64'hfedc_ba98_7654_3210, '0);
    send(CMD_LATEST, '0, '0, CNT_W'(2));
    send(CMD_RANGE, 64'd2, '0, CNT_W'(2));
    send(CMD_LATEST, '0, '0, CNT_W'(1));
    send(CMD_RANGE, '0, '0, CNT_W'(3));
    send(CMD_PUSH, 64'd3, '1, '0);
    // Zero capacity rejects pushes; a capacity below the fill drops the oldest.
    write_capacity('0);
    send(CMD_PUSH, 64'd10, '1, '0);
    write_capacity(CNT_W'(3));
    send(CMD_PUSH, 64'd6, 64'h5a5a_a5a5_5a5a_a5a5, '0);
    send(CMD_LATEST, '0, '0, CNT_W'(4));
    send(CMD_RANGE, 64'd5, '0, CNT_W'(2));
    newest = 64'd6;

    // Random transactions under varied capacity and idling.
    run_phase('1, 0, 0, 90);
    run_phase(CNT_W'(64), 70, 0, 70);
    run_phase(CNT_W'(1), 0, 70, 50);
    run_phase(CNT_W'(5), 18, 18, 60);
    run_phase('0, 0, 0, 30);
    run_phase(CNT_W'(64), 0, 70, 80);
    run_phase(CNT_W'(40), 18, 18, 30);

    // Ids at the top of the 64-bit range.
    idle_pct  = 0;
    stall_pct = 0;
    write_capacity(CNT_W'(64));
    send(CMD_PUSH, ID_TOP - 1, '1, '0);
    send(CMD_PUSH, ID_TOP, {$urandom, $urandom}, '0);
    send(CMD_LATEST, '0, '0, CNT_W'(2));
    send(CMD_RANGE, ID_TOP - 1, '0, CNT_W'(2));
    send(CMD_PUSH, ID_TOP, '0, '0);
    drain();

    if (fail_cnt == 0) begin
      $display("tb_id_ordered_pulse_ring_buffer_top OK");
    end else begin
      $display("tb_id_ordered_pulse_ring_buffer_top NOT OK");
    end
    $finish;
  end

endmodule
